// ===== hdl/rgb_channel_histogram_top_defines.svh =====
// assertion macros for the rgb channel histogram
// no dependencies; included by files that check their own logic
`ifndef RGB_CHANNEL_HISTOGRAM_TOP_DEFINES_SVH
`define RGB_CHANNEL_HISTOGRAM_TOP_DEFINES_SVH

`ifndef SYNTH
`define RCH_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rch assertion failed");
`define RCH_ASSERT_NR(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("rch assertion failed");
`else
`define RCH_ASSERT(name, clk, rst_n, prop)
`define RCH_ASSERT_NR(name, clk, prop)
`endif

`endif

// ===== hdl/rch_pkg.sv =====
// shared types and constants of the rgb channel histogram
// no dependencies
package rch_pkg;

  localparam int unsigned NUM_CH = 3;

  typedef enum logic [1:0] {
    REQ_COUNT = 2'd0,
    REQ_READ  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COUNT_WR,
    ST_READ_OUT
  } state_e;

  typedef struct packed {
    logic rd_pix;
    logic rd_bin;
    logic clr_we;
    logic cnt_we;
    logic ptr_clr;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic ptr_last;
    logic out_free;
  } stat_t;

endpackage

// ===== hdl/rch_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module rch_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/rch_ctrl.sv =====
// request sequencer of the rgb channel histogram
// depends on rch_pkg and the defines header
`include "rgb_channel_histogram_top_defines.svh"

module rch_ctrl import rch_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic [1:0] req_type_i,
  input  stat_t      stat_i,
  output cmd_t       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (stat_i.ptr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          unique case (req_e'(req_type_i))
            REQ_COUNT: begin
              cmd_o.rd_pix = 1'b1;
              state_d      = ST_COUNT_WR;
            end
            REQ_READ: begin
              cmd_o.rd_bin = 1'b1;
              state_d      = ST_READ_OUT;
            end
            REQ_CLEAR: begin
              cmd_o.ptr_clr = 1'b1;
              state_d       = ST_CLEAR;
            end
            default: ;
          endcase
        end
      end
      ST_COUNT_WR: begin
        cmd_o.cnt_we = 1'b1;
        state_d      = ST_IDLE;
      end
      ST_READ_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  `RCH_ASSERT_NR(a_one_writer, clk_i, !(cmd_o.clr_we && cmd_o.cnt_we))
  `RCH_ASSERT(a_count_writes_back, clk_i, rst_ni,
    (s_tvalid_i && s_tready_o && req_type_i == REQ_COUNT) |=> cmd_o.cnt_we)
  `RCH_ASSERT(a_load_when_free, clk_i, rst_ni, cmd_o.load_out |-> stat_i.out_free)
  `RCH_ASSERT(a_read_then_out, clk_i, rst_ni,
    (s_tvalid_i && s_tready_o && req_type_i == REQ_READ) |=> state_q == ST_READ_OUT)

endmodule

// ===== hdl/rch_datapath.sv =====
// bin memories, saturating increment, clear pointer and result register
// depends on rch_pkg and rch_ram
module rch_datapath import rch_pkg::*; #(
  parameter int unsigned PIXEL_BITS = 8,
  parameter int unsigned COUNT_BITS = 17,
  parameter int unsigned IN_W       = 32,
  parameter int unsigned OUT_W      = 56
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output stat_t            stat_o,
  input  logic [IN_W-1:0]  s_tdata_i,
  output logic             m_tvalid_o,
  input  logic             m_tready_i,
  output logic [OUT_W-1:0] m_tdata_o
);

  localparam int unsigned NUM_BINS = 2 ** PIXEL_BITS;

  logic [PIXEL_BITS-1:0] pix_in [NUM_CH];
  logic [PIXEL_BITS-1:0] pix_q  [NUM_CH];
  logic [PIXEL_BITS-1:0] bin_in;
  logic [COUNT_BITS-1:0] rdata  [NUM_CH];
  logic [COUNT_BITS-1:0] count_q [NUM_CH];
  logic [PIXEL_BITS-1:0] ptr_q;
  logic                  m_tvalid_q;

  assign bin_in = s_tdata_i[NUM_CH*PIXEL_BITS +: PIXEL_BITS];

  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
    logic [COUNT_BITS-1:0] inc;
    logic [COUNT_BITS-1:0] wdata;
    logic [PIXEL_BITS-1:0] waddr;
    logic [PIXEL_BITS-1:0] raddr;

    assign pix_in[ch] = s_tdata_i[ch*PIXEL_BITS +: PIXEL_BITS];
    // saturating increment
    assign inc   = (&rdata[ch]) ? rdata[ch] : rdata[ch] + COUNT_BITS'(1);
    assign wdata = cmd_i.clr_we ? '0 : inc;
    assign waddr = cmd_i.clr_we ? ptr_q : pix_q[ch];
    assign raddr = cmd_i.rd_bin ? bin_in : pix_in[ch];

    rch_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (NUM_BINS)
    ) u_bins (
      .clk_i   (clk_i),
      .we_i    (cmd_i.clr_we | cmd_i.cnt_we),
      .waddr_i (waddr),
      .wdata_i (wdata),
      .re_i    (cmd_i.rd_pix | cmd_i.rd_bin),
      .raddr_i (raddr),
      .rdata_o (rdata[ch])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q      <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.clr_we) begin
        ptr_q <= ptr_q + PIXEL_BITS'(1);
      end
      if (cmd_i.load_out) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (cmd_i.rd_pix) begin
        pix_q[ch] <= pix_in[ch];
      end
      if (cmd_i.load_out) begin
        count_q[ch] <= rdata[ch];
      end
    end
  end

  always_comb begin
    m_tdata_o = '0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      m_tdata_o[ch*COUNT_BITS +: COUNT_BITS] = count_q[ch];
    end
  end

  assign m_tvalid_o      = m_tvalid_q;
  assign stat_o.ptr_last = &ptr_q;
  assign stat_o.out_free = !m_tvalid_q || m_tready_i;

endmodule

// ===== hdl/rgb_channel_histogram_top.sv =====
// rgb channel histogram top level: three saturating 2^PIXEL_BITS-bin histograms
// depends on rch_pkg, rch_ctrl and rch_datapath
//
// channel  dir  tdata (low bit up)                          tuser
// s_axis   in   red, green, blue, bin_index (PIXEL_BITS ea) req_type
// m_axis   out  red, green, blue count (COUNT_BITS each)    -
//
// count: bin read, then saturating write back through the ram port
// read: bin read, then result load, plus any wait while the result register is still held
// clear: pointer reset, then one bin of each ram per cycle up to the last bin
// after reset a clear pass over all 2^PIXEL_BITS bins runs before s_axis_tready_o rises
// m_axis stall holds only reads and requests behind a held read; counts and clears do not wait on it
module rgb_channel_histogram_top import rch_pkg::*; #(
  parameter int unsigned PIXEL_BITS = 8,
  parameter int unsigned COUNT_BITS = 17,
  parameter int unsigned IN_W       = ((4 * PIXEL_BITS + 7) / 8) * 8,
  parameter int unsigned OUT_W      = ((3 * COUNT_BITS + 7) / 8) * 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [IN_W-1:0]  s_axis_tdata_i,  // red, green, blue, bin_index
  input  logic [1:0]       s_axis_tuser_i,  // req_type
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OUT_W-1:0] m_axis_tdata_o   // red_count, green_count, blue_count
);

  cmd_t  cmd;
  stat_t stat;

  rch_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .req_type_i (s_axis_tuser_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rch_datapath #(
    .PIXEL_BITS (PIXEL_BITS),
    .COUNT_BITS (COUNT_BITS),
    .IN_W       (IN_W),
    .OUT_W      (OUT_W)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .s_tdata_i  (s_axis_tdata_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o)
  );

endmodule
